// ===== sv/ede_pkg.sv =====
// Shared constants, types and helpers for the edit distance engine.
package ede_pkg;

    // Length limits
    localparam int MAX_PATTERN = 64;
    localparam int MAX_TEXT    = 4096;

    // Field widths
    localparam int KIND_W = 2;
    localparam int SYM_W  = 8;
    localparam int DIST_W = 13;

    // Largest reportable distance
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Pattern index, pattern length and text length widths
    localparam int PI_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int PL_W = $clog2(MAX_PATTERN + 1);
    localparam int TL_W = $clog2(MAX_TEXT + 1);

    // Row value width: holds max(text, pattern) + 1, never narrower than the result
    localparam int VAL_RAW = $clog2(((MAX_TEXT > MAX_PATTERN) ? MAX_TEXT : MAX_PATTERN) + 2);
    localparam int VAL_W   = (VAL_RAW > DIST_W) ? VAL_RAW : DIST_W;

    typedef logic [VAL_W-1:0] t_val;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        K_CLEAR  = 2'd0,
        K_APPEND = 2'd1,
        K_TEXT   = 2'd2,
        K_FINISH = 2'd3
    } t_kind;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    // Control from the sequencer to the storage
    typedef struct packed {
        logic [PI_W-1:0]  rd_addr;
        logic             row_we;
        logic [PI_W-1:0]  row_waddr;
        logic             row_clear;
        logic             pat_we;
        logic [PI_W-1:0]  pat_waddr;
        logic [SYM_W-1:0] pat_wdata;
    } t_mem_ctl;

    // Clamp a row value to the result width
    function automatic logic [DIST_W-1:0] sat_dist(input t_val v);
        logic [DIST_W-1:0] res;
        if (v > t_val'(DIST_MAX)) begin
            res = DIST_MAX;
        end else begin
            res = v[DIST_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/ede_in_if.sv =====
// Input channel: item kind and symbol with valid/ready handshake.
interface ede_in_if;
    logic                       valid;
    logic                       ready;
    logic [ede_pkg::KIND_W-1:0] kind;
    logic [ede_pkg::SYM_W-1:0]  symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

// ===== sv/ede_out_if.sv =====
// Result channel: distance and overflow flag with valid/ready handshake.
interface ede_out_if;
    logic                       valid;
    logic                       ready;
    logic [ede_pkg::DIST_W-1:0] distance;
    logic                       overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);
endinterface

// ===== sv/ede_cell.sv =====
// One dynamic-programming cell: minimum of insert, delete and substitute costs.
module ede_cell (
    input  ede_pkg::t_val             i_up,
    input  ede_pkg::t_val             i_left,
    input  ede_pkg::t_val             i_diag,
    input  logic [ede_pkg::SYM_W-1:0] i_pat,
    input  logic [ede_pkg::SYM_W-1:0] i_sym,
    output ede_pkg::t_val             o_best
);
    import ede_pkg::*;

    t_val up_cost;
    t_val left_cost;
    t_val sub_cost;
    t_val min_ul;

    // Costs of the three edits
    assign up_cost   = i_up + t_val'(1);
    assign left_cost = i_left + t_val'(1);
    assign sub_cost  = i_diag + t_val'(i_pat != i_sym);

    // Three-way minimum
    assign min_ul = (left_cost < up_cost) ? left_cost : up_cost;
    assign o_best = (sub_cost < min_ul) ? sub_cost : min_ul;

endmodule

// ===== sv/ede_store.sv =====
// Pattern memory, row memory and per-entry row valid bits.
module ede_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ede_pkg::t_mem_ctl         i_ctl,
    input  ede_pkg::t_val             i_row_wdata,
    output ede_pkg::t_val             o_up,
    output logic [ede_pkg::SYM_W-1:0] o_pat
);
    import ede_pkg::*;

    logic [SYM_W-1:0]       r_pat_mem [MAX_PATTERN];
    t_val                   r_row_mem [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_row_vld;

    logic [SYM_W-1:0] r_pat_rd;
    t_val             r_row_rd;
    logic             r_rd_vld;
    logic [PI_W-1:0]  r_rd_addr;

    // Pattern memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.pat_we) begin
            r_pat_mem[i_ctl.pat_waddr] <= i_ctl.pat_wdata;
        end
        r_pat_rd <= r_pat_mem[i_ctl.rd_addr];
    end

    // Row memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.row_we) begin
            r_row_mem[i_ctl.row_waddr] <= i_row_wdata;
        end
        r_row_rd  <= r_row_mem[i_ctl.rd_addr];
        r_rd_addr <= i_ctl.rd_addr;
    end

    // Valid bits: an entry not yet written since the last restart reads as its column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.row_clear) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_ctl.row_we) begin
                r_row_vld[i_ctl.row_waddr] <= 1'b1;
            end
            r_rd_vld <= r_row_vld[i_ctl.rd_addr];
        end
    end

    assign o_up  = r_rd_vld ? r_row_rd : (t_val'(r_rd_addr) + t_val'(1));
    assign o_pat = r_pat_rd;

endmodule

// ===== sv/ede_ctrl.sv =====
// Sequencer: item decode, row sweep over the pattern, result register.
module ede_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ede_in_if.sink                    i_in,
    ede_out_if.source                 o_out,
    input  ede_pkg::t_val             i_up,
    input  ede_pkg::t_val             i_best,
    output ede_pkg::t_mem_ctl         o_ctl,
    output ede_pkg::t_val             o_left,
    output ede_pkg::t_val             o_diag,
    output logic [ede_pkg::SYM_W-1:0] o_sym
);
    import ede_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [PL_W-1:0]  r_plen;
    logic [TL_W-1:0]  r_tlen;
    logic             r_ovf;
    logic [PI_W-1:0]  r_k;
    logic [SYM_W-1:0] r_sym;
    t_val             r_diag;
    t_val             r_left;
    logic             r_out_valid;
    logic [DIST_W-1:0] r_out_dist;
    logic             r_out_ovf;

    t_kind kind;
    logic  acc;
    logic  pat_full;
    logic  text_full;
    logic  plen_zero;
    logic  last_cell;
    logic  out_free;
    logic  start_sweep;
    logic  fin_load;
    logic [PI_W-1:0] last_addr;

    // Decode
    assign kind       = t_kind'(i_in.kind);
    assign acc        = i_in.valid & i_in.ready;
    assign pat_full   = (r_plen >= PL_W'(MAX_PATTERN));
    assign text_full  = (r_tlen >= TL_W'(MAX_TEXT));
    assign plen_zero  = (r_plen == '0);
    assign last_cell  = (PL_W'(r_k) == (r_plen - PL_W'(1)));
    assign out_free   = !r_out_valid || o_out.ready;
    assign last_addr  = PI_W'(r_plen - PL_W'(1));
    assign start_sweep = acc && (kind == K_TEXT) && !text_full && !plen_zero;
    assign fin_load   = (r_state == ST_FINISH) && out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_sweep) begin
                    n_state = ST_SWEEP;
                end else if (acc && (kind == K_FINISH)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_SWEEP: begin
                if (last_cell) begin
                    n_state = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: handshake and memory control
    always_comb begin
        i_in.ready      = (r_state == ST_IDLE);
        o_ctl.rd_addr   = '0;
        o_ctl.row_we    = 1'b0;
        o_ctl.row_waddr = r_k;
        o_ctl.row_clear = 1'b0;
        o_ctl.pat_we    = 1'b0;
        o_ctl.pat_waddr = PI_W'(r_plen);
        o_ctl.pat_wdata = i_in.symbol;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && (kind == K_FINISH)) begin
                    o_ctl.rd_addr = last_addr;
                end
                if (acc && (kind == K_APPEND) && !pat_full) begin
                    o_ctl.pat_we    = 1'b1;
                    o_ctl.row_clear = 1'b1;
                end
                if (acc && (kind == K_CLEAR)) begin
                    o_ctl.row_clear = 1'b1;
                end
            end
            ST_SWEEP: begin
                o_ctl.rd_addr = r_k + PI_W'(1);
                o_ctl.row_we  = 1'b1;
            end
            ST_FINISH: begin
                o_ctl.rd_addr   = last_addr;
                o_ctl.row_clear = out_free;
            end
            default: ;
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_plen      <= '0;
            r_tlen      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (acc) begin
                unique case (kind)
                    K_CLEAR: begin
                        r_plen <= '0;
                        r_tlen <= '0;
                        r_ovf  <= 1'b0;
                    end
                    K_APPEND: begin
                        if (pat_full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_plen <= r_plen + PL_W'(1);
                            r_tlen <= '0;
                        end
                    end
                    K_TEXT: begin
                        if (text_full) begin
                            r_ovf <= 1'b1;
                        end else if (plen_zero) begin
                            r_tlen <= r_tlen + TL_W'(1);
                        end
                    end
                    K_FINISH: ;
                    default: ;
                endcase
            end
            if ((r_state == ST_SWEEP) && last_cell) begin
                r_tlen <= r_tlen + TL_W'(1);
            end
            // Result register: load on finish, drop on transfer
            if (fin_load) begin
                r_out_valid <= 1'b1;
                r_ovf       <= 1'b0;
                r_tlen      <= '0;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sweep datapath and result payload
    always_ff @(posedge i_clk) begin
        if (start_sweep) begin
            r_k    <= '0;
            r_sym  <= i_in.symbol;
            r_diag <= t_val'(r_tlen);
            r_left <= t_val'(r_tlen) + t_val'(1);
        end else if (r_state == ST_SWEEP) begin
            r_k    <= r_k + PI_W'(1);
            r_diag <= i_up;
            r_left <= i_best;
        end
        if (fin_load) begin
            r_out_dist <= plen_zero ? sat_dist(t_val'(r_tlen)) : sat_dist(i_up);
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_left = r_left;
    assign o_diag = r_diag;
    assign o_sym  = r_sym;

    assign o_out.valid    = r_out_valid;
    assign o_out.distance = r_out_dist;
    assign o_out.overflow = r_out_ovf;

endmodule

// ===== sv/edit_distance_engine.sv =====
// Top level of the edit distance engine.
// Levenshtein distance between a stored pattern (up to 64 symbols) and a streamed text
// (up to 4096 symbols). An append restarts the current text. A text symbol for a
// non-empty pattern starts a sweep of the row: one cell of the row per cycle through a
// single shared cell unit, limited by the one read and one write port of the row memory.
// No new item is taken until the sweep is done. A finish item performs one row memory
// read and then waits only while the previous result has not yet been transferred; the
// result sits in an output register. Overlong pattern or text symbols are dropped and
// flagged on the next result. No clearing pass follows reset.
module edit_distance_engine (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ede_in_if.sink    i_in,
    ede_out_if.source o_out
);
    import ede_pkg::*;

    t_mem_ctl         mem_ctl;
    t_val             up_val;
    t_val             left_val;
    t_val             diag_val;
    t_val             best_val;
    logic [SYM_W-1:0] pat_sym;
    logic [SYM_W-1:0] text_sym;

    // Sequencer
    ede_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_up    (up_val),
        .i_best  (best_val),
        .o_ctl   (mem_ctl),
        .o_left  (left_val),
        .o_diag  (diag_val),
        .o_sym   (text_sym)
    );

    // Pattern and row storage
    ede_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (mem_ctl),
        .i_row_wdata (best_val),
        .o_up        (up_val),
        .o_pat       (pat_sym)
    );

    // Shared cell unit
    ede_cell u_cell (
        .i_up   (up_val),
        .i_left (left_val),
        .i_diag (diag_val),
        .i_pat  (pat_sym),
        .i_sym  (text_sym),
        .o_best (best_val)
    );

endmodule
